@@ hw/rtl/cpmd_pkg.sv @@
// shared constants and types for the closest pair minimum distance block
// used by cpmd_dist and closest_pair_min_distance_top; no dependencies
package cpmd_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 16;
    localparam int POINT_W    = 2 * COORD_W;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int SUM_W      = SQ_W + 1;
    localparam int DIST_W     = 34;
    localparam int OUT_W      = 33;

    typedef enum logic [2:0] {
        S_LOAD,
        S_RD_I,
        S_LAT_I,
        S_DIFF,
        S_SQ_X,
        S_SQ_Y,
        S_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clr;
        logic diff_en;
        logic sq_x_en;
        logic sq_y_en;
        logic cmp_en;
    } t_dist_ctrl;

endpackage

@@ hw/rtl/closest_pair_min_distance_top.sv @@
// closest pair of points: smallest squared distance over a loaded point set
// depends on cpmd_pkg and cpmd_dist
//
// Points load one per cycle into a 1024-entry point store while o_in_ready is
// high; the point with i_last_point set ends the set and starts an exhaustive
// search over all stored pairs. Points beyond 1024 are dropped and reported
// through o_capacity_exceeded. The search runs on one memory read port and one
// shared squaring multiplier: for each outer point it reads that point (S_RD_I,
// S_LAT_I), then steps each pair through S_DIFF, S_SQ_X, S_SQ_Y and S_CMP. With
// fewer than two stored points there is no search and the distance is 0. The
// block takes no points during the search. A result waits in an output
// register; loading of the next set may start while it waits.
module closest_pair_min_distance_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [cpmd_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [cpmd_pkg::COORD_W-1:0] i_point_y,
    input  logic                              i_last_point,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [cpmd_pkg::OUT_W-1:0]        o_min_sq_distance,
    output logic                              o_capacity_exceeded
);

    localparam int CNT_W = cpmd_pkg::CNT_W;
    localparam int IDX_W = cpmd_pkg::IDX_W;

    cpmd_pkg::t_state r_state, n_state;

    logic [cpmd_pkg::POINT_W-1:0] r_point_store [cpmd_pkg::MAX_POINTS];
    logic [cpmd_pkg::POINT_W-1:0] r_rdata;
    logic [cpmd_pkg::POINT_W-1:0] r_pt_i;

    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;
    logic             r_dropped, n_dropped;

    logic                         r_out_valid;
    logic [cpmd_pkg::OUT_W-1:0]   r_min;
    logic                         r_cap;

    logic                         w_in_xfer;
    logic                         w_has_room;
    logic [CNT_W-1:0]             w_cnt_after;
    logic                         w_more_j;
    logic                         w_more_i;
    logic                         w_rd_en;
    logic [CNT_W-1:0]             w_rd_addr;
    logic                         w_done_load;
    cpmd_pkg::t_dist_ctrl         w_ctrl;
    logic [cpmd_pkg::DIST_W-1:0]  w_best;

    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_has_room  = r_count < CNT_W'(cpmd_pkg::MAX_POINTS);
    assign w_cnt_after = w_has_room ? r_count + CNT_W'(1) : r_count;
    assign w_more_j    = (r_j + CNT_W'(1)) < r_count;
    assign w_more_i    = (r_i + CNT_W'(2)) < r_count;
    assign w_done_load = (r_state == cpmd_pkg::S_DONE) && !r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cpmd_pkg::S_LOAD: begin
                if (w_in_xfer && i_last_point) begin
                    n_state = (w_cnt_after < CNT_W'(2)) ? cpmd_pkg::S_DONE : cpmd_pkg::S_RD_I;
                end
            end
            cpmd_pkg::S_RD_I:  n_state = cpmd_pkg::S_LAT_I;
            cpmd_pkg::S_LAT_I: n_state = cpmd_pkg::S_DIFF;
            cpmd_pkg::S_DIFF:  n_state = cpmd_pkg::S_SQ_X;
            cpmd_pkg::S_SQ_X:  n_state = cpmd_pkg::S_SQ_Y;
            cpmd_pkg::S_SQ_Y:  n_state = cpmd_pkg::S_CMP;
            cpmd_pkg::S_CMP: begin
                if (w_more_j) begin
                    n_state = cpmd_pkg::S_DIFF;
                end else if (w_more_i) begin
                    n_state = cpmd_pkg::S_RD_I;
                end else begin
                    n_state = cpmd_pkg::S_DONE;
                end
            end
            cpmd_pkg::S_DONE: begin
                if (!r_out_valid) begin
                    n_state = cpmd_pkg::S_LOAD;
                end
            end
            default: n_state = cpmd_pkg::S_LOAD;
        endcase
    end

    // outputs and index updates
    always_comb begin
        o_in_ready = 1'b0;
        w_rd_en    = 1'b0;
        w_rd_addr  = r_j;
        w_ctrl     = '0;
        n_count    = r_count;
        n_dropped  = r_dropped;
        n_i        = r_i;
        n_j        = r_j;
        case (r_state)
            cpmd_pkg::S_LOAD: begin
                o_in_ready = 1'b1;
                if (w_in_xfer) begin
                    n_count = w_cnt_after;
                    if (!w_has_room) begin
                        n_dropped = 1'b1;
                    end
                    if (i_last_point) begin
                        w_ctrl.clr = 1'b1;
                        n_i        = '0;
                        n_j        = CNT_W'(1);
                    end
                end
            end
            cpmd_pkg::S_RD_I: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_i;
            end
            cpmd_pkg::S_LAT_I: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_j;
            end
            cpmd_pkg::S_DIFF: w_ctrl.diff_en = 1'b1;
            cpmd_pkg::S_SQ_X: w_ctrl.sq_x_en = 1'b1;
            cpmd_pkg::S_SQ_Y: w_ctrl.sq_y_en = 1'b1;
            cpmd_pkg::S_CMP: begin
                w_ctrl.cmp_en = 1'b1;
                if (w_more_j) begin
                    n_j       = r_j + CNT_W'(1);
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_j + CNT_W'(1);
                end else if (w_more_i) begin
                    n_i = r_i + CNT_W'(1);
                    n_j = r_i + CNT_W'(2);
                end
            end
            cpmd_pkg::S_DONE: begin
                if (!r_out_valid) begin
                    n_count   = '0;
                    n_dropped = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cpmd_pkg::S_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_i       <= n_i;
            r_j       <= n_j;
        end
    end

    // point store: written while loading, read during the search
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && w_has_room) begin
            r_point_store[r_count[IDX_W-1:0]] <= {i_point_y, i_point_x};
        end
        if (w_rd_en) begin
            r_rdata <= r_point_store[w_rd_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == cpmd_pkg::S_LAT_I) begin
            r_pt_i <= r_rdata;
        end
    end

    cpmd_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_pt_a  (r_pt_i),
        .i_pt_b  (r_rdata),
        .o_best  (w_best)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done_load) begin
            r_min <= (r_count < CNT_W'(2)) ? '0 : w_best[cpmd_pkg::OUT_W-1:0];
            r_cap <= r_dropped;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_min_sq_distance   = r_min;
    assign o_capacity_exceeded = r_cap;

endmodule

@@ hw/rtl/cpmd_dist.sv @@
// squared distance datapath with one shared squaring multiplier and running minimum
// depends on cpmd_pkg
module cpmd_dist (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cpmd_pkg::t_dist_ctrl              i_ctrl,
    input  logic [cpmd_pkg::POINT_W-1:0]      i_pt_a,
    input  logic [cpmd_pkg::POINT_W-1:0]      i_pt_b,
    output logic [cpmd_pkg::DIST_W-1:0]       o_best
);

    localparam int CW = cpmd_pkg::COORD_W;

    logic [CW-1:0]                 r_abs_x;
    logic [CW-1:0]                 r_abs_y;
    logic [cpmd_pkg::SQ_W-1:0]     r_sq_x;
    logic [cpmd_pkg::SUM_W-1:0]    r_dist;
    logic [cpmd_pkg::DIST_W-1:0]   r_best;

    logic signed [CW:0]            w_dx;
    logic signed [CW:0]            w_dy;
    logic [CW:0]                   w_ax;
    logic [CW:0]                   w_ay;
    logic [CW-1:0]                 w_op;
    logic [cpmd_pkg::SQ_W-1:0]     w_prod;

    // x in the low half, y in the high half
    assign w_dx = $signed({i_pt_a[CW-1], i_pt_a[CW-1:0]})
                - $signed({i_pt_b[CW-1], i_pt_b[CW-1:0]});
    assign w_dy = $signed({i_pt_a[2*CW-1], i_pt_a[2*CW-1:CW]})
                - $signed({i_pt_b[2*CW-1], i_pt_b[2*CW-1:CW]});
    assign w_ax = w_dx[CW] ? (CW+1)'(-w_dx) : (CW+1)'(w_dx);
    assign w_ay = w_dy[CW] ? (CW+1)'(-w_dy) : (CW+1)'(w_dy);

    // shared multiplier squares x then y
    assign w_op   = i_ctrl.sq_y_en ? r_abs_y : r_abs_x;
    assign w_prod = w_op * w_op;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.diff_en) begin
            r_abs_x <= w_ax[CW-1:0];
            r_abs_y <= w_ay[CW-1:0];
        end
        if (i_ctrl.sq_x_en) begin
            r_sq_x <= w_prod;
        end
        if (i_ctrl.sq_y_en) begin
            r_dist <= {1'b0, r_sq_x} + {1'b0, w_prod};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '1;
        end else if (i_ctrl.clr) begin
            r_best <= '1;
        end else if (i_ctrl.cmp_en && ({1'b0, r_dist} < r_best)) begin
            r_best <= {1'b0, r_dist};
        end
    end

    assign o_best = r_best;

endmodule

@@ test/min_distance_checker.sv @@
`timescale 1ns / 1ps
// checker for closest_pair_min_distance_top: predicts each set's result and compares
// depends on cpmd_pkg; instantiated by testbench beside the block
module min_distance_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic signed [cpmd_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [cpmd_pkg::COORD_W-1:0] i_point_y,
    input  logic                               i_last_point,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [cpmd_pkg::OUT_W-1:0]         i_min_sq_distance,
    input  logic                               i_capacity_exceeded,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    typedef struct packed {
        logic [cpmd_pkg::OUT_W-1:0] min_dist;
        logic                       dropped;
    } t_set_result;

    logic signed [cpmd_pkg::COORD_W-1:0] set_x [cpmd_pkg::MAX_POINTS];
    logic signed [cpmd_pkg::COORD_W-1:0] set_y [cpmd_pkg::MAX_POINTS];
    int                                  set_count;
    bit                                  set_dropped;
    t_set_result                         expected_results [$];

    // exhaustive search over the stored points of the current set
    function automatic logic [cpmd_pkg::OUT_W-1:0] closest_sq_distance();
        logic [cpmd_pkg::DIST_W-1:0] best;
        longint                      dx;
        longint                      dy;
        longint                      d;
        int                          i;
        int                          j;
        best = '1;
        if (set_count < 2) begin
            return '0;
        end
        for (i = 0; i < set_count - 1; i++) begin
            for (j = i + 1; j < set_count; j++) begin
                dx = longint'(set_x[i]) - longint'(set_x[j]);
                dy = longint'(set_y[i]) - longint'(set_y[j]);
                d  = dx * dx + dy * dy;
                if (d < best) begin
                    best = d[cpmd_pkg::DIST_W-1:0];
                end
            end
        end
        return best[cpmd_pkg::OUT_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t ns mismatch: %s: got %0d, want %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_set_result want;
        if (!i_rst_n) begin
            set_count    = 0;
            set_dropped  = 1'b0;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (set_count < cpmd_pkg::MAX_POINTS) begin
                    set_x[set_count] = i_point_x;
                    set_y[set_count] = i_point_y;
                    set_count++;
                end else begin
                    set_dropped = 1'b1;
                end
                if (i_last_point) begin
                    want.min_dist = closest_sq_distance();
                    want.dropped  = set_dropped;
                    expected_results = {expected_results, want};
                    set_count   = 0;
                    set_dropped = 1'b0;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result transfer with none pending", i_min_sq_distance, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_min_sq_distance !== want.min_dist) begin
                        report_mismatch("min_sq_distance", i_min_sq_distance, want.min_dist);
                    end
                    if (i_capacity_exceeded !== want.dropped) begin
                        report_mismatch("capacity_exceeded", i_capacity_exceeded, want.dropped);
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// top of the closest pair testbench: clock, reset, point sets, result stalls, verdict
// depends on cpmd_pkg, closest_pair_min_distance_top and min_distance_checker
module testbench;

    localparam int HOLD_CYCLES    = 800;
    localparam int DRAIN_CYCLES   = 300;
    localparam int POINT_TARGET   = 1800;
    // slowest search (full store) three times over, plus the long receiver hold-off
    localparam int WATCHDOG_LIMIT =
        3 * (2 * cpmd_pkg::MAX_POINTS * (cpmd_pkg::MAX_POINTS - 1)
             + 2 * cpmd_pkg::MAX_POINTS) + HOLD_CYCLES;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 i_in_valid;
    logic                                 o_in_ready;
    logic signed [cpmd_pkg::COORD_W-1:0]  i_point_x;
    logic signed [cpmd_pkg::COORD_W-1:0]  i_point_y;
    logic                                 i_last_point;
    logic                                 o_out_valid;
    logic                                 i_out_ready;
    logic [cpmd_pkg::OUT_W-1:0]           o_min_sq_distance;
    logic                                 o_capacity_exceeded;

    int fail_count;
    int pending;
    int points_sent;
    int idle_cycles;
    bit calm;
    bit hold_req;

    closest_pair_min_distance_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_point_x           (i_point_x),
        .i_point_y           (i_point_y),
        .i_last_point        (i_last_point),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_min_sq_distance   (o_min_sq_distance),
        .o_capacity_exceeded (o_capacity_exceeded)
    );

    min_distance_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_point_x           (i_point_x),
        .i_point_y           (i_point_y),
        .i_last_point        (i_last_point),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_min_sq_distance   (o_min_sq_distance),
        .i_capacity_exceeded (o_capacity_exceeded),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [cpmd_pkg::COORD_W-1:0] corner_coord();
        case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'h8001;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'h7FFF;
        endcase
    endfunction

    task automatic send_point(input logic [cpmd_pkg::COORD_W-1:0] x,
                              input logic [cpmd_pkg::COORD_W-1:0] y,
                              input bit last);
        while (!calm && $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_point_x    <= x;
        i_point_y    <= y;
        i_last_point <= last;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        points_sent++;
    endtask

    // spread sets use the full coordinate range only; points past the store
    // repeat the first one, so counting them would give a distance of zero
    task automatic send_set(input int n, input bit spread);
        logic [cpmd_pkg::COORD_W-1:0] base_x;
        logic [cpmd_pkg::COORD_W-1:0] base_y;
        logic [cpmd_pkg::COORD_W-1:0] first_x;
        logic [cpmd_pkg::COORD_W-1:0] first_y;
        logic [cpmd_pkg::COORD_W-1:0] x;
        logic [cpmd_pkg::COORD_W-1:0] y;
        int                           k;
        int                           r;
        base_x = 16'($urandom);
        base_y = 16'($urandom);
        for (k = 0; k < n; k++) begin
            r = spread ? 0 : int'($urandom_range(9));
            if (k >= cpmd_pkg::MAX_POINTS) begin
                x = first_x;
                y = first_y;
            end else if (r < 3) begin
                x = 16'($urandom);
                y = 16'($urandom);
            end else if (r < 5) begin
                x = corner_coord();
                y = corner_coord();
            end else begin
                x = base_x + 16'($urandom_range(64)) - 16'd32;
                y = base_y + 16'($urandom_range(64)) - 16'd32;
            end
            if (k == 0) begin
                first_x = x;
                first_y = y;
            end
            send_point(x, y, k == n - 1);
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_ready <= calm || ($urandom_range(99) >= 25);
            end
        end
    end

    // ends the run when no transfer happens for too long
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        bit overflow_done;
        bit held;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_point_x     = '0;
        i_point_y     = '0;
        i_last_point  = 1'b0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        points_sent   = 0;
        overflow_done = 1'b0;
        held          = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single points, including a corner
        send_point(16'h0000, 16'h0000, 1'b1);
        send_point(16'h8000, 16'h7FFF, 1'b1);
        // opposite corners give the largest distance
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h7FFF, 16'h7FFF, 1'b1);
        send_point(16'h7FFF, 16'h8000, 1'b0);
        send_point(16'h8000, 16'h7FFF, 1'b1);
        // identical points
        send_point(16'h0005, -16'sd3, 1'b0);
        send_point(16'h0005, -16'sd3, 1'b1);
        send_point(16'h8000, 16'h0000, 1'b0);
        send_point(16'h7FFF, 16'h0000, 1'b0);
        send_point(16'h8000, 16'h0001, 1'b1);
        send_point(16'h0001, 16'h0001, 1'b0);
        send_point(16'h0004, 16'h0005, 1'b0);
        send_point(-16'sd2, -16'sd3, 1'b0);
        send_point(16'd100, 16'd100, 1'b1);
        send_point(16'h0000, 16'h7FFF, 1'b0);
        send_point(16'hFFFF, 16'h8000, 1'b1);

        while (points_sent < POINT_TARGET) begin
            if (!overflow_done && points_sent >= 700) begin
                send_set(cpmd_pkg::MAX_POINTS + int'($urandom_range(1, 3)), 1'b1);
                overflow_done = 1'b1;
            end else begin
                if (!held && points_sent >= 300) begin
                    hold_req = 1'b1;
                    held     = 1'b1;
                end
                calm = (points_sent >= 450 && points_sent < 650);
                send_set(int'($urandom_range(1, 12)), 1'b0);
            end
        end
        i_in_valid <= 1'b0;
        calm = 1'b0;
        // let the checker record the last transfer before polling its count
        @(posedge i_clk);

        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
